// ===== hdl/pbpm_pkg.sv =====
// ----------------------------------------------------------------------------
// Page buffer pool manager package
// Shared types, codes and sizes for the slot cells and the pool top level.
// ----------------------------------------------------------------------------
`default_nettype none

package pbpm_pkg;

	localparam int POOL_SLOTS = 16;
	localparam int SLOT_W     = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int TABLE_W    = 8;
	localparam int BLOCK_W    = 31;
	localparam int PIN_W      = 16;
	localparam int SLOT_OUT_W = 4;

	localparam logic [PIN_W-1:0] PIN_MAX = {PIN_W{1'b1}};

	typedef enum logic [2:0] {
		MODE_FIND     = 3'd0,
		MODE_LOAD     = 3'd1,
		MODE_PIN      = 3'd2,
		MODE_UNPIN    = 3'd3,
		MODE_MODIFIED = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		ST_HIT        = 3'd0,
		ST_LOADED     = 3'd1,
		ST_NOT_FOUND  = 3'd2,
		ST_UNPIN_ZERO = 3'd3,
		ST_ALL_PINNED = 3'd4
	} status_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic [TABLE_W-1:0] table_id;
		logic [BLOCK_W-1:0] block_no;
	} req_t;

	typedef struct packed {
		logic [2:0]            status;
		logic [SLOT_OUT_W-1:0] slot;
		logic [PIN_W-1:0]      pin_level;
		logic                  writeback_needed;
		logic [TABLE_W-1:0]    writeback_table;
		logic [BLOCK_W-1:0]    writeback_block;
		logic                  read_needed;
	} rsp_t;

	// Record that walks down the chain, one cell per cycle.
	typedef struct packed {
		logic               valid;
		logic               hit;
		logic [SLOT_W-1:0]  hit_idx;
		logic [PIN_W-1:0]   hit_pins;
		logic               free;
		logic [SLOT_W-1:0]  free_idx;
		logic               free_valid;
		logic               free_dirty;
		logic [TABLE_W-1:0] free_table;
		logic [BLOCK_W-1:0] free_block;
	} scan_t;

	// Update broadcast to all cells once a scan has finished.
	typedef struct packed {
		logic               en;
		logic [SLOT_W-1:0]  idx;
		logic               load;
		logic               pin_inc;
		logic               pin_dec;
		logic               set_dirty;
		logic [TABLE_W-1:0] table_id;
		logic [BLOCK_W-1:0] block_no;
	} commit_t;

endpackage

`default_nettype wire

// ===== hdl/page_buffer_pool_manager_top.sv =====
// ----------------------------------------------------------------------------
// Page buffer pool manager
// Pool of page slots with lookup and first-unpinned replacement, built as a
// chain of slot cells that a scan record walks through.
// ----------------------------------------------------------------------------
// The result strobe rises once the accepted item has passed go_q, the scan
// register of every slot cell and the result register. The scan record visits
// one slot cell per cycle, and only one item is in the chain at a time.
// busy is high from the accepting edge until the result cycle, in which a new
// item may already be started. The receiver cannot stall the result.
// Reset (arst_n low) empties the pool at once: every slot invalid, unpinned.
`default_nettype none

module page_buffer_pool_manager_top
	import pbpm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire req_t req,
	output logic      done,
	output rsp_t      rsp
);

	// The held request is broadcast to every cell while its scan runs.
	req_t    req_q;
	logic    busy_q;
	logic    go_q;
	logic    done_q;
	rsp_t    rsp_q;
	logic    accept;

	// chain[0] is the empty record entering the first cell; chain[i + 1] is
	// what cell i hands on. The last entry is the finished scan.
	scan_t   chain [POOL_SLOTS+1];
	scan_t   fin;
	commit_t commit;
	rsp_t    rsp_d;

	assign accept = start && !busy_q;
	assign busy   = busy_q;
	assign done   = done_q;
	assign rsp    = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			go_q   <= 1'b0;
		end else begin
			go_q <= accept;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fin.valid) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
	end

	always_comb begin
		chain[0]       = '0;
		chain[0].valid = go_q;
	end

	for (genvar i = 0; i < POOL_SLOTS; i++) begin : g_cell
		pbpm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_idx  (SLOT_W'(i)),
			.req_table (req_q.table_id),
			.req_block (req_q.block_no),
			.scan_in   (chain[i]),
			.scan_out  (chain[i+1]),
			.commit    (commit)
		);
	end

	assign fin = chain[POOL_SLOTS];

	// Decide the outcome from the finished scan. A hit wins over a load; a
	// miss in a loading mode takes the first slot with no pins, and if there
	// is none every slot is pinned. Unused mode codes act like a plain find.
	always_comb begin
		rsp_d            = '0;
		rsp_d.status     = ST_NOT_FOUND;
		commit           = '0;
		commit.en        = fin.valid;
		commit.idx       = fin.hit_idx;
		commit.table_id  = req_q.table_id;
		commit.block_no  = req_q.block_no;
		if (fin.hit) begin
			rsp_d.status    = ST_HIT;
			rsp_d.slot      = SLOT_OUT_W'(fin.hit_idx);
			rsp_d.pin_level = fin.hit_pins;
		end
		unique case (req_q.mode)
			MODE_LOAD, MODE_PIN: begin
				if (fin.hit) begin
					if (req_q.mode == MODE_PIN) begin
						commit.pin_inc = 1'b1;
						if (fin.hit_pins != PIN_MAX) begin
							rsp_d.pin_level = fin.hit_pins + PIN_W'(1);
						end
					end
				end else if (fin.free) begin
					rsp_d.status           = ST_LOADED;
					rsp_d.slot             = SLOT_OUT_W'(fin.free_idx);
					rsp_d.pin_level        = (req_q.mode == MODE_PIN) ? PIN_W'(1) : '0;
					rsp_d.read_needed      = 1'b1;
					rsp_d.writeback_needed = fin.free_valid && fin.free_dirty;
					if (fin.free_valid && fin.free_dirty) begin
						rsp_d.writeback_table = fin.free_table;
						rsp_d.writeback_block = fin.free_block;
					end
					commit.idx     = fin.free_idx;
					commit.load    = 1'b1;
					commit.pin_inc = (req_q.mode == MODE_PIN);
				end else begin
					rsp_d.status = ST_ALL_PINNED;
				end
			end
			MODE_UNPIN: begin
				if (fin.hit) begin
					if (fin.hit_pins == '0) begin
						rsp_d.status = ST_UNPIN_ZERO;
					end else begin
						rsp_d.pin_level = fin.hit_pins - PIN_W'(1);
						commit.pin_dec  = 1'b1;
					end
				end
			end
			MODE_MODIFIED: begin
				commit.set_dirty = fin.hit;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fin.valid) begin
			rsp_q <= rsp_d;
		end
	end

`ifndef SYNTHESIS
	logic [POOL_SLOTS-1:0] scan_live;

	always_comb begin
		for (int k = 0; k < POOL_SLOTS; k++) begin
			scan_live[k] = chain[k+1].valid;
		end
	end

	// Only one scan record may be in the chain at any time.
	a_one_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({go_q, scan_live}))
		else $error("more than one scan in the slot chain");

	// The result cycle is the first cycle in which the next item may start.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	// An accepted item keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	// A read is requested exactly when a page was loaded on a miss.
	a_read_load: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.read_needed == (rsp.status == ST_LOADED)))
		else $error("read request does not match load status");

	// A write-back only ever accompanies a load.
	a_wb_load: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.writeback_needed) |-> rsp.read_needed)
		else $error("write-back reported without a load");
`endif

endmodule

`default_nettype wire

// ===== hdl/pbpm_cell.sv =====
// ----------------------------------------------------------------------------
// Page buffer pool slot cell
// Holds one pool slot, folds its match and free status into the passing scan
// record, and applies the commit addressed to it.
// ----------------------------------------------------------------------------
`default_nettype none

module pbpm_cell
	import pbpm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [SLOT_W-1:0]  cell_idx,
	input  wire logic [TABLE_W-1:0] req_table,
	input  wire logic [BLOCK_W-1:0] req_block,
	input  wire scan_t              scan_in,
	output scan_t                   scan_out,
	input  wire commit_t            commit
);

	logic               valid_q;
	logic [TABLE_W-1:0] table_q;
	logic [BLOCK_W-1:0] block_q;
	logic [PIN_W-1:0]   pins_q;
	logic               dirty_q;
	scan_t              scan_d;
	scan_t              scan_q;
	logic               match;
	logic               sel;

	assign match = valid_q && (table_q == req_table) && (block_q == req_block);
	assign sel   = commit.en && (commit.idx == cell_idx);

	always_comb begin
		scan_d = scan_in;
		if (!scan_in.hit && match) begin
			scan_d.hit      = 1'b1;
			scan_d.hit_idx  = cell_idx;
			scan_d.hit_pins = pins_q;
		end
		if (!scan_in.free && (pins_q == '0)) begin
			scan_d.free       = 1'b1;
			scan_d.free_idx   = cell_idx;
			scan_d.free_valid = valid_q;
			scan_d.free_dirty = dirty_q;
			scan_d.free_table = table_q;
			scan_d.free_block = block_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else begin
			scan_q <= scan_d;
		end
	end

	assign scan_out = scan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			table_q <= '0;
			block_q <= '0;
			pins_q  <= '0;
			dirty_q <= 1'b0;
		end else if (sel) begin
			if (commit.load) begin
				valid_q <= 1'b1;
				table_q <= commit.table_id;
				block_q <= commit.block_no;
				pins_q  <= commit.pin_inc ? PIN_W'(1) : '0;
				dirty_q <= 1'b0;
			end else begin
				if (commit.pin_inc && (pins_q != PIN_MAX)) begin
					pins_q <= pins_q + PIN_W'(1);
				end
				if (commit.pin_dec && (pins_q != '0)) begin
					pins_q <= pins_q - PIN_W'(1);
				end
				if (commit.set_dirty) begin
					dirty_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== bench/page_buffer_pool_manager_top_tb.sv =====
// ----------------------------------------------------------------------------
// Page buffer pool manager testbench
// Drives lookup, load, pin, unpin and modify requests into the pool. A
// scoreboard keeps its own copy of the slot table and checks every result
// field by field. The run covers directed corner cases, biased random traffic
// and a short run of repeated pins on one page.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_buffer_pool_manager_top_tb;
	import pbpm_pkg::*;

	// Modes 5 to 7 carry no meaning and must act as a plain find.
	localparam logic [2:0] MODE_SPARE_A = 3'd5;
	localparam logic [2:0] MODE_SPARE_B = 3'd6;
	localparam logic [2:0] MODE_SPARE_C = 3'd7;

	localparam int NUM_KEYS       = 24;
	localparam int ITEMS_PER_LEG  = 140;
	localparam int NUM_LEGS       = 5;
	localparam int MAX_GAP        = 2 * (POOL_SLOTS + 2) + 4;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PIN_RUN        = 8;

	// Scoreboard: mirrors the slot table, predicts one result per accepted
	// request and compares what the pool returns against the oldest one.
	class pool_checker;
		logic               valid [POOL_SLOTS];
		logic [TABLE_W-1:0] tbl   [POOL_SLOTS];
		logic [BLOCK_W-1:0] blk   [POOL_SLOTS];
		logic [PIN_W-1:0]   pins  [POOL_SLOTS];
		logic               dirty [POOL_SLOTS];
		rsp_t               pending [$];
		int                 errors;

		function new();
			for (int i = 0; i < POOL_SLOTS; i++) begin
				valid[i] = 1'b0;
				tbl[i]   = '0;
				blk[i]   = '0;
				pins[i]  = '0;
				dirty[i] = 1'b0;
			end
			errors = 0;
		endfunction

		function void note_request(req_t r);
			rsp_t want;
			int   idx;
			want        = '0;
			want.status = ST_NOT_FOUND;
			// Lowest valid slot holding this page, if any.
			idx = -1;
			for (int i = POOL_SLOTS - 1; i >= 0; i--)
				if (valid[i] && tbl[i] == r.table_id && blk[i] == r.block_no)
					idx = i;
			case (r.mode)
			MODE_LOAD, MODE_PIN: begin
				if (idx >= 0) begin
					want.status = ST_HIT;
				end else begin
					// Victim is the first slot with no pins, valid or not.
					for (int i = POOL_SLOTS - 1; i >= 0; i--)
						if (pins[i] == '0)
							idx = i;
					if (idx < 0) begin
						want.status = ST_ALL_PINNED;
					end else begin
						if (valid[idx] && dirty[idx]) begin
							want.writeback_needed = 1'b1;
							want.writeback_table  = tbl[idx];
							want.writeback_block  = blk[idx];
						end
						valid[idx]       = 1'b1;
						tbl[idx]         = r.table_id;
						blk[idx]         = r.block_no;
						pins[idx]        = '0;
						dirty[idx]       = 1'b0;
						want.read_needed = 1'b1;
						want.status      = ST_LOADED;
					end
				end
				if (idx >= 0 && r.mode == MODE_PIN && pins[idx] != PIN_MAX)
					pins[idx] = pins[idx] + 1'b1;
			end
			MODE_UNPIN: begin
				if (idx >= 0) begin
					if (pins[idx] == '0) begin
						want.status = ST_UNPIN_ZERO;
					end else begin
						pins[idx]   = pins[idx] - 1'b1;
						want.status = ST_HIT;
					end
				end
			end
			MODE_MODIFIED: begin
				if (idx >= 0) begin
					dirty[idx]  = 1'b1;
					want.status = ST_HIT;
				end
			end
			default: begin
				if (idx >= 0)
					want.status = ST_HIT;
			end
			endcase
			if (idx >= 0) begin
				want.slot      = SLOT_OUT_W'(idx);
				want.pin_level = pins[idx];
			end
			pending.push_back(want);
		endfunction

		task report_mismatch(string what, longint unsigned got_v, longint unsigned want_v);
			errors++;
			$display("error at %0t: %s got 0x%0h expected 0x%0h", $time, what, got_v,
				want_v);
		endtask

		task check_response(rsp_t got);
			rsp_t want;
			if (pending.size() == 0) begin
				report_mismatch("result with nothing pending, status", got.status, 0);
			end else begin
				want = pending.pop_front();
				if (got.status !== want.status)
					report_mismatch("status", got.status, want.status);
				if (got.slot !== want.slot)
					report_mismatch("slot", got.slot, want.slot);
				if (got.pin_level !== want.pin_level)
					report_mismatch("pin_level", got.pin_level, want.pin_level);
				if (got.writeback_needed !== want.writeback_needed)
					report_mismatch("writeback_needed", got.writeback_needed,
						want.writeback_needed);
				if (got.writeback_table !== want.writeback_table)
					report_mismatch("writeback_table", got.writeback_table,
						want.writeback_table);
				if (got.writeback_block !== want.writeback_block)
					report_mismatch("writeback_block", got.writeback_block,
						want.writeback_block);
				if (got.read_needed !== want.read_needed)
					report_mismatch("read_needed", got.read_needed, want.read_needed);
			end
		endtask

		task finish_check();
			if (pending.size() != 0)
				report_mismatch("results never returned, count", pending.size(), 0);
		endtask
	endclass

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	pool_checker sb;

	// Pages that the random traffic keeps coming back to, so that hits,
	// repins and evictions of modified pages all happen often.
	logic [TABLE_W-1:0] key_table [NUM_KEYS];
	logic [BLOCK_W-1:0] key_block [NUM_KEYS];

	// Chance in percent that the sender idles before an item.
	int idle_pct = 24;
	int stall_cycles = 0;

	always #2 clk = ~clk;

	page_buffer_pool_manager_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	// Sampling happens at the rising edge, before the pool's own registers
	// move. The result is checked before a request taken at the same edge is
	// noted; the queue keeps them in order either way.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_response(rsp);
			if (start && !busy)
				sb.note_request(req);
		end
	end

	// Watchdog: too many cycles in a row with neither a request taken nor a
	// result returned means the pool has hung.
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n)
			stall_cycles = 0;
		else
			stall_cycles = stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired after %0d quiet cycles", stall_cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Present one item at the falling edge, optionally after a random gap, and
	// hold it until the pool takes it. start stays high across back-to-back
	// items, so the pool also sees a request in its result cycle.
	task automatic issue_request(input req_t r);
		int gap;
		@(negedge clk);
		if ($urandom_range(99) < idle_pct) begin
			gap   = $urandom_range(1, MAX_GAP);
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		req   = r;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic issue(input logic [2:0] m, input logic [TABLE_W-1:0] t,
		input logic [BLOCK_W-1:0] b);
		req_t r;
		r.mode     = m;
		r.table_id = t;
		r.block_no = b;
		issue_request(r);
	endtask

	// Stop sending and wait until every outstanding result has come back.
	task automatic wait_quiet();
		@(negedge clk);
		start = 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	// Random request: mostly one of the recurring pages, sometimes a stray
	// page anywhere in the table and block space. The mix leans toward
	// pinning or toward unpinning so the pool fills up and drains again.
	function automatic req_t random_request(bit pin_heavy);
		req_t r;
		int   roll;
		int   k;
		roll = $urandom_range(99);
		if (pin_heavy) begin
			if (roll < 35)      r.mode = MODE_PIN;
			else if (roll < 50) r.mode = MODE_LOAD;
			else if (roll < 65) r.mode = MODE_FIND;
			else if (roll < 80) r.mode = MODE_MODIFIED;
			else if (roll < 95) r.mode = MODE_UNPIN;
			else                r.mode = 3'($urandom_range(MODE_SPARE_A, MODE_SPARE_C));
		end else begin
			if (roll < 15)      r.mode = MODE_PIN;
			else if (roll < 25) r.mode = MODE_LOAD;
			else if (roll < 40) r.mode = MODE_FIND;
			else if (roll < 55) r.mode = MODE_MODIFIED;
			else if (roll < 95) r.mode = MODE_UNPIN;
			else                r.mode = 3'($urandom_range(MODE_SPARE_A, MODE_SPARE_C));
		end
		if ($urandom_range(99) < 10) begin
			r.table_id = TABLE_W'($urandom);
			r.block_no = BLOCK_W'($urandom);
		end else begin
			k          = $urandom_range(NUM_KEYS - 1);
			r.table_id = key_table[k];
			r.block_no = key_block[k];
		end
		return r;
	endfunction

	initial begin
		int                 drain_cnt [POOL_SLOTS];
		logic [TABLE_W-1:0] drain_tbl [POOL_SLOTS];
		logic [BLOCK_W-1:0] drain_blk [POOL_SLOTS];
		logic [BLOCK_W-1:0] pin_block;

		sb = new();

		// Two of the recurring pages sit at the extremes of the fields.
		key_table[0] = '0;
		key_block[0] = '0;
		key_table[1] = '1;
		key_block[1] = '1;
		for (int i = 2; i < NUM_KEYS; i++) begin
			key_table[i] = TABLE_W'($urandom);
			key_block[i] = BLOCK_W'($urandom);
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. An empty pool misses on every lookup.
		issue(MODE_FIND, key_table[0], key_block[0]);
		issue(MODE_UNPIN, key_table[1], key_block[1]);
		// First load lands in slot 0; then hit, pin, unpin, and an unpin at
		// zero that must leave the page alone.
		issue(MODE_LOAD, key_table[1], key_block[1]);
		issue(MODE_FIND, key_table[1], key_block[1]);
		issue(MODE_PIN, key_table[1], key_block[1]);
		issue(MODE_UNPIN, key_table[1], key_block[1]);
		issue(MODE_UNPIN, key_table[1], key_block[1]);
		issue(MODE_MODIFIED, key_table[1], key_block[1]);
		// Unused modes behave as a find, hit or miss.
		issue(MODE_SPARE_A, key_table[1], key_block[1]);
		issue(MODE_SPARE_B, key_table[0], key_block[0]);
		issue(MODE_SPARE_C, key_table[1], key_block[1]);
		// Slot 0 is unpinned and modified, so this miss evicts it with a
		// write-back of the old page.
		issue(MODE_LOAD, key_table[0], key_block[0]);
		issue(MODE_PIN, key_table[0], key_block[0]);
		// Pin fresh pages into every other slot, then miss twice with every
		// slot pinned.
		for (int i = 2; i <= POOL_SLOTS; i++)
			issue(MODE_PIN, key_table[i], key_block[i]);
		issue(MODE_LOAD, key_table[POOL_SLOTS + 1], key_block[POOL_SLOTS + 1]);
		issue(MODE_PIN, key_table[POOL_SLOTS + 2], key_block[POOL_SLOTS + 2]);
		wait_quiet();

		// Random part in legs that alternate between draining and filling
		// the pool. One leg runs without any idling. Between legs the sender
		// holds off until every result is back.
		for (int leg = 0; leg < NUM_LEGS; leg++) begin
			idle_pct = (leg == 3) ? 0 : 24;
			for (int n = 0; n < ITEMS_PER_LEG; n++)
				issue_request(random_request(leg % 2 == 1));
			wait_quiet();
		end

		// Release every pin that is left, so the closing pin run starts with
		// free slots. The counts are taken while the pool is idle.
		idle_pct = 0;
		for (int i = 0; i < POOL_SLOTS; i++) begin
			drain_cnt[i] = sb.pins[i];
			drain_tbl[i] = sb.tbl[i];
			drain_blk[i] = sb.blk[i];
		end
		for (int i = 0; i < POOL_SLOTS; i++)
			repeat (drain_cnt[i]) issue(MODE_UNPIN, drain_tbl[i], drain_blk[i]);

		// Pin one page several times over, step it back down and mark it
		// modified; it must stay resident across a load of another page.
		pin_block = BLOCK_W'($urandom);
		repeat (PIN_RUN) issue(MODE_PIN, key_table[3], pin_block);
		issue(MODE_UNPIN, key_table[3], pin_block);
		issue(MODE_MODIFIED, key_table[3], pin_block);
		issue(MODE_LOAD, key_table[0], key_block[0]);
		issue(MODE_FIND, key_table[3], pin_block);

		wait_quiet();
		repeat (POOL_SLOTS + 6) @(posedge clk);
		sb.finish_check();
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
